@@ sv/buffer_slot_pool_core_assert.svh @@
// Assertion macros for the buffer slot pool.
// Each use expands to one labeled concurrent assertion on clk, off during reset.
`ifndef BUFFER_SLOT_POOL_CORE_ASSERT_SVH
`define BUFFER_SLOT_POOL_CORE_ASSERT_SVH

// Same-cycle implication.
`define BSP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buffer slot pool assertion failed");

// Next-cycle implication.
`define BSP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buffer slot pool assertion failed");

`endif

@@ sv/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg
// Types and constants shared by the buffer slot pool modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsp_pkg;

	localparam int KIND_W  = 3;
	localparam int SLOT_W  = 4;
	// slot numbers are 4 bits, so the pool never exceeds this
	localparam int MAX_POOL = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_CREATE      = 3'd0,
		KIND_ACQUIRE     = 3'd1,
		KIND_PUT         = 3'd2,
		KIND_RELEASE     = 3'd3,
		KIND_RELEASE_ALL = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
	} op_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              status;
	} result_t;

endpackage

`default_nettype wire

@@ sv/bsp_if.sv @@
// ----------------------------------------------------------------------------
// bsp_in_if / bsp_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bsp_in_if;
	logic                       valid;
	logic                       ready;
	logic [bsp_pkg::KIND_W-1:0] kind;
	logic [bsp_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output kind, output slot, input ready);
	modport sink   (input valid, input kind, input slot, output ready);
endinterface

interface bsp_out_if;
	logic                       valid;
	logic                       ready;
	logic [bsp_pkg::SLOT_W-1:0] slot_out;
	logic                       status;

	modport source (output valid, output slot_out, output status, input ready);
	modport sink   (input valid, input slot_out, input status, output ready);
endinterface

`default_nettype wire

@@ sv/bsp_prio_enc.sv @@
// ----------------------------------------------------------------------------
// bsp_prio_enc
// Lowest-set-bit priority encoder over the slot bitmap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsp_prio_enc #(
	parameter int WIDTH = 16
) (
	input  wire logic [WIDTH-1:0]           bits,
	output logic                            hit,
	output logic [bsp_pkg::SLOT_W-1:0]      index
);

	always_comb begin
		index = '0;
		// scan downward so the lowest set bit wins
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (bits[i]) begin
				index = bsp_pkg::SLOT_W'(i);
			end
		end
		hit = |bits;
	end

endmodule

`default_nettype wire

@@ sv/bsp_map_unit.sv @@
// ----------------------------------------------------------------------------
// bsp_map_unit
// Present/available bitmaps and the combinational operation decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsp_map_unit #(
	parameter int POOL = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              update,
	input  wire bsp_pkg::op_t      op,
	output bsp_pkg::result_t       result
);

	localparam logic [POOL-1:0] ONE = POOL'(1);

	logic [POOL-1:0] present_q;
	logic [POOL-1:0] avail_q;
	logic [POOL-1:0] present_d;
	logic [POOL-1:0] avail_d;

	logic [POOL-1:0] slot_bit;
	logic [POOL-1:0] free_bit;
	logic [POOL-1:0] grab_bit;

	logic                       free_hit;
	logic                       grab_hit;
	logic [bsp_pkg::SLOT_W-1:0] free_idx;
	logic [bsp_pkg::SLOT_W-1:0] grab_idx;

	bsp_prio_enc #(.WIDTH(POOL)) u_free_enc (
		.bits  (~present_q),
		.hit   (free_hit),
		.index (free_idx)
	);

	bsp_prio_enc #(.WIDTH(POOL)) u_grab_enc (
		.bits  (present_q & avail_q),
		.hit   (grab_hit),
		.index (grab_idx)
	);

	// slots beyond the pool shift out to zero, so they never match
	assign slot_bit = ONE << op.slot;
	assign free_bit = ONE << free_idx;
	assign grab_bit = ONE << grab_idx;

	always_comb begin
		present_d     = present_q;
		avail_d       = avail_q;
		result.slot   = op.slot;
		result.status = 1'b1;
		unique case (op.kind)
			bsp_pkg::KIND_CREATE: begin
				result.slot = '0;
				if (free_hit) begin
					present_d     = present_q | free_bit;
					avail_d       = avail_q | free_bit;
					result.slot   = free_idx;
					result.status = 1'b0;
				end
			end
			bsp_pkg::KIND_ACQUIRE: begin
				result.slot = '0;
				if (grab_hit) begin
					avail_d       = avail_q & ~grab_bit;
					result.slot   = grab_idx;
					result.status = 1'b0;
				end
			end
			bsp_pkg::KIND_PUT: begin
				if (|(present_q & slot_bit)) begin
					avail_d       = avail_q | slot_bit;
					result.status = 1'b0;
				end
			end
			bsp_pkg::KIND_RELEASE: begin
				if (|(present_q & slot_bit)) begin
					present_d     = present_q & ~slot_bit;
					avail_d       = avail_q & ~slot_bit;
					result.status = 1'b0;
				end
			end
			bsp_pkg::KIND_RELEASE_ALL: begin
				present_d     = '0;
				avail_d       = '0;
				result.status = 1'b0;
			end
			default: begin
				result.status = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			avail_q   <= '0;
		end else if (update) begin
			present_q <= present_d;
			avail_q   <= avail_d;
		end
	end

endmodule

`default_nettype wire

@@ sv/buffer_slot_pool_core.sv @@
// ----------------------------------------------------------------------------
// buffer_slot_pool_core
// Bitmap slot allocator: create, acquire, put back, release, release all.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   kind[2:0], slot[3:0]
//  rsp      out  valid/ready   slot_out[3:0], status
//
//  One item per cycle unless rsp stalls.
//  The item register feeds the bitmap decode, which writes the result register.
//  Bitmaps update as the item moves into the result register, so the next item
//  sees them. arst_n clears both bitmaps and both valid flags.
//  A stalled rsp holds its result; req stays ready until the item register
//  is also full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buffer_slot_pool_core #(
	parameter int SLOT_COUNT = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bsp_in_if.sink     req,
	bsp_out_if.source  rsp
);

	localparam int POOL_SIZE = (SLOT_COUNT < bsp_pkg::MAX_POOL) ? SLOT_COUNT
		: bsp_pkg::MAX_POOL;

	logic             valid_s1;
	bsp_pkg::op_t     op_s1;
	logic             valid_s2;
	bsp_pkg::result_t res_s2;
	bsp_pkg::result_t res_d;
	logic             advance;

	assign advance   = !valid_s2 || rsp.ready;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1.kind <= bsp_pkg::kind_t'(req.kind);
			op_s1.slot <= req.slot;
		end
	end

	bsp_map_unit #(.POOL(POOL_SIZE)) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.update (valid_s1 && advance),
		.op     (op_s1),
		.result (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign rsp.valid    = valid_s2;
	assign rsp.slot_out = res_s2.slot;
	assign rsp.status   = res_s2.status;

endmodule

`default_nettype wire

@@ sv/bsp_checker.sv @@
// ----------------------------------------------------------------------------
// bsp_checker
// Port-level checks for the buffer slot pool, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "buffer_slot_pool_core_assert.svh"

module bsp_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       req_valid,
	input wire logic                       req_ready,
	input wire logic [bsp_pkg::KIND_W-1:0] req_kind,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [bsp_pkg::SLOT_W-1:0] rsp_slot_out,
	input wire logic                       rsp_status
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// a held result keeps its payload
	`BSP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot_out) && $stable(rsp_status))

	// input backs up only when both stages are full and output stalls
	`BSP_ASSERT_NOW(a_bp_cause, !req_ready, rsp_valid && !rsp_ready)

	// with the output draining, a taken item passes the item register and shows up from the result register
	`BSP_ASSERT_NEXT(a_latency, req_acc ##1 rsp_ready, rsp_valid)

	// release all always succeeds
	`BSP_ASSERT_NEXT(a_rel_all_ok, (req_acc && req_kind == bsp_pkg::KIND_RELEASE_ALL) ##1 rsp_ready, rsp_valid && !rsp_status)

	// unknown kinds always fail
	`BSP_ASSERT_NEXT(a_bad_kind, (req_acc && req_kind > bsp_pkg::KIND_RELEASE_ALL) ##1 rsp_ready, rsp_valid && rsp_status)

endmodule

bind buffer_slot_pool_core bsp_checker u_bsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_kind     (req.kind),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_slot_out (rsp.slot_out),
	.rsp_status   (rsp.status)
);

`default_nettype wire

@@ test/slot_pool_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_checker
// Follows the present and available maps from every request taken by the pool,
// works out the response each request must get, and compares the responses
// as they leave, in order. Counts mismatches and the responses still due.
// ----------------------------------------------------------------------------

module slot_pool_checker
	import bsp_pkg::*;
#(
	parameter int SLOT_COUNT = 16
) (
	input  logic clk,
	input  logic arst_n,
	bsp_in_if    req,
	bsp_out_if   rsp,
	output int   mismatches,
	output int   pending
);

	// slot numbers are 4 bits, so at most MAX_POOL slots exist
	localparam int POOL = (SLOT_COUNT < MAX_POOL) ? SLOT_COUNT : MAX_POOL;

	logic [MAX_POOL-1:0] present_bits;
	logic [MAX_POOL-1:0] avail_bits;
	result_t             rsp_due_q[$];

	function automatic bit lowest_set(input logic [MAX_POOL-1:0] cand,
		output logic [SLOT_W-1:0] idx);
		idx = '0;
		for (int i = 0; i < POOL; i++) begin
			if (cand[i]) begin
				idx = SLOT_W'(i);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Applies one request to the maps and returns the response it earns.
	function automatic result_t pool_op_predict(input logic [KIND_W-1:0] kind,
		input logic [SLOT_W-1:0] slot);
		result_t           r;
		logic [SLOT_W-1:0] pick;
		logic              hit;
		r.slot   = slot;
		r.status = 1'b1;
		hit      = (int'(slot) < POOL) && present_bits[slot];
		case (kind)
			KIND_CREATE: begin
				r.slot = '0;
				if (lowest_set(~present_bits, pick)) begin
					present_bits[pick] = 1'b1;
					avail_bits[pick]   = 1'b1;
					r.slot             = pick;
					r.status           = 1'b0;
				end
			end
			KIND_ACQUIRE: begin
				r.slot = '0;
				if (lowest_set(present_bits & avail_bits, pick)) begin
					avail_bits[pick] = 1'b0;
					r.slot           = pick;
					r.status         = 1'b0;
				end
			end
			KIND_PUT: begin
				if (hit) begin
					avail_bits[slot] = 1'b1;
					r.status         = 1'b0;
				end
			end
			KIND_RELEASE: begin
				if (hit) begin
					present_bits[slot] = 1'b0;
					avail_bits[slot]   = 1'b0;
					r.status           = 1'b0;
				end
			end
			KIND_RELEASE_ALL: begin
				present_bits = '0;
				avail_bits   = '0;
				r.status     = 1'b0;
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			present_bits = '0;
			avail_bits   = '0;
			rsp_due_q.delete();
			mismatches   = 0;
			pending      = 0;
		end else begin
			// a request taken at this edge cannot be answered at the same edge
			if (rsp.valid && rsp.ready) begin
				if (rsp_due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response with none due: slot %0d status %0b",
							$time, rsp.slot_out, rsp.status);
				end else begin
					want = rsp_due_q.pop_front();
					if (rsp.slot_out !== want.slot || rsp.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected slot %0d status %0b, got slot %0d status %0b",
								$time, want.slot, want.status, rsp.slot_out, rsp.status);
					end
				end
			end
			if (req.valid && req.ready)
				rsp_due_q.push_back(pool_op_predict(req.kind, req.slot));
			pending = rsp_due_q.size();
		end
	end

endmodule

@@ test/tb_buffer_slot_pool_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buffer_slot_pool_core
// Drives create, acquire, put back, release, release all and unknown kinds
// into the slot pool: a directed opening that fills and empties the pool, then
// random traffic under three patterns of request gaps and response stalls.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------

module tb_buffer_slot_pool_core;
	import bsp_pkg::*;

	localparam int SLOT_COUNT  = 16;
	localparam int CYCLE_LIMIT = 200000;
	// kinds past the last defined operation
	localparam logic [KIND_W-1:0] KIND_UNKNOWN_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN_LAST  = 3'd7;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   mismatches;
	int   pending;
	int   cycles = 0;

	bsp_in_if  req ();
	bsp_out_if rsp ();

	buffer_slot_pool_core #(.SLOT_COUNT(SLOT_COUNT)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	slot_pool_checker #(.SLOT_COUNT(SLOT_COUNT)) pool_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offers one item after a random gap and returns at the edge that takes it.
	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.kind  <= kind;
		req.slot  <= slot;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	// Holds off new items until every response due has come back.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int count);
		int                pick;
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(999);
			// release all kept rare so the pool gets to fill up now and then
			if (pick < 320)
				kind = KIND_CREATE;
			else if (pick < 540)
				kind = KIND_ACQUIRE;
			else if (pick < 740)
				kind = KIND_PUT;
			else if (pick < 940)
				kind = KIND_RELEASE;
			else if (pick < 955)
				kind = KIND_RELEASE_ALL;
			else
				kind = KIND_W'($urandom_range(KIND_UNKNOWN_LAST, KIND_UNKNOWN_FIRST));
			// low slots are the ones handed out first
			if ($urandom_range(3) != 0)
				slot = SLOT_W'($urandom_range(7));
			else
				slot = SLOT_W'($urandom_range(15));
			send_op(kind, slot);
			if ($urandom_range(99) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.kind      = KIND_CREATE;
		req.slot      = '0;
		rsp.ready     = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 30;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_op(KIND_ACQUIRE, 4'd5);       // nothing available
		send_op(KIND_RELEASE, 4'd15);      // slot not present
		repeat (MAX_POOL)
			send_op(KIND_CREATE, 4'd15);
		send_op(KIND_CREATE, 4'd0);        // pool full
		send_op(KIND_ACQUIRE, 4'd0);
		send_op(KIND_PUT, 4'd0);
		send_op(KIND_PUT, 4'd3);           // already available
		send_op(KIND_RELEASE, 4'd15);
		send_op(KIND_RELEASE_ALL, 4'd10);
		send_op(KIND_UNKNOWN_LAST, 4'd9);
		wait_drained();

		run_phase(14, 63, 283);
		run_phase(63, 14, 283);
		run_phase(0, 0, 284);

		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/bsp_pkg.sv
sv/bsp_if.sv
sv/bsp_prio_enc.sv
sv/bsp_map_unit.sv
sv/buffer_slot_pool_core.sv
sv/bsp_checker.sv
test/slot_pool_checker.sv
test/tb_buffer_slot_pool_core.sv
